[rtl/pare_pkg.sv]
// ----------------------------------------------------------------------------
// pare_pkg
// Shared types and constants for the premultiply / row extent core.
// ----------------------------------------------------------------------------
package pare_pkg;

    // configuration register indexes
    localparam logic CFG_IMAGE_WIDTH  = 1'b0;
    localparam logic CFG_IMAGE_HEIGHT = 1'b1;

    // register and field widths
    localparam int CFG_W   = 13;
    localparam int PIXEL_W = 32;
    localparam int FIRST_W = 13;
    localparam int LAST_W  = 12;

    // configuration reset values
    localparam logic [CFG_W-1:0] WIDTH_RESET  = 13'd256;
    localparam logic [CFG_W-1:0] HEIGHT_RESET = 13'd240;

    // alpha code of an opaque pixel
    localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;

    // queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_AW    = 1;
    localparam int QUEUE_CW    = 2;

    // one classified pixel
    typedef struct packed {
        logic [PIXEL_W-1:0] px;
        logic               nz;
    } t_item;

    // queue status seen by the back end
    typedef struct packed {
        logic  valid;
        t_item item;
    } t_queue_out;

endpackage

[rtl/pare_front.sv]
// ----------------------------------------------------------------------------
// pare_front
// Accepts pixels, premultiplies the color bytes and flags nonzero results.
// ----------------------------------------------------------------------------
module pare_front
    import pare_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [PIXEL_W-1:0] i_pixel_in,
    output logic               o_push,
    input  logic               i_full,
    output t_item              o_item
);

    logic       r_vld;
    logic       n_vld;
    t_item      r_item;
    t_item      n_item;
    logic [7:0] alpha;
    logic [8:0] scale;
    logic [16:0] prod_r;
    logic [16:0] prod_g;
    logic [16:0] prod_b;
    logic [PIXEL_W-1:0] px_mul;
    logic       take;

    // premultiply: byte * (alpha + 1) >> 8
    always_comb begin
        alpha  = i_pixel_in[31:24];
        scale  = {1'b0, alpha} + 9'd1;
        prod_r = 17'(scale) * 17'(i_pixel_in[23:16]);
        prod_g = 17'(scale) * 17'(i_pixel_in[15:8]);
        prod_b = 17'(scale) * 17'(i_pixel_in[7:0]);
        if (alpha == ALPHA_OPAQUE) begin
            px_mul = i_pixel_in;
        end else begin
            px_mul = {alpha, prod_r[15:8], prod_g[15:8], prod_b[15:8]};
        end
    end

    // stage register, drained into the queue
    assign o_push  = r_vld && !i_full;
    assign o_stall = r_vld && i_full;
    assign take    = i_valid && !o_stall;
    assign o_item  = r_item;

    always_comb begin
        n_vld  = r_vld;
        n_item = r_item;
        if (o_push) begin
            n_vld = 1'b0;
        end
        if (take) begin
            n_vld     = 1'b1;
            n_item.px = px_mul;
            n_item.nz = (px_mul != '0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= n_vld;
        end
        r_item <= n_item;
    end

endmodule

[rtl/pare_queue.sv]
// ----------------------------------------------------------------------------
// pare_queue
// Short queue that lets front and back stall independently.
// ----------------------------------------------------------------------------
module pare_queue
    import pare_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_push,
    input  t_item      i_item,
    output logic       o_full,
    input  logic       i_pop,
    output t_queue_out o_q
);

    t_item               r_mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] r_wptr;
    logic [QUEUE_AW-1:0] r_rptr;
    logic [QUEUE_CW-1:0] r_count;
    logic [QUEUE_AW-1:0] n_wptr;
    logic [QUEUE_AW-1:0] n_rptr;
    logic [QUEUE_CW-1:0] n_count;

    assign o_full      = (r_count == QUEUE_CW'(QUEUE_DEPTH));
    assign o_q.valid   = (r_count != '0);
    assign o_q.item    = r_mem[r_rptr];

    // pointer and fill update
    always_comb begin
        n_wptr  = r_wptr;
        n_rptr  = r_rptr;
        n_count = r_count;
        if (i_push) begin
            n_wptr = r_wptr + 1'b1;
        end
        if (i_pop) begin
            n_rptr = r_rptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    // entry storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_item;
        end
    end

    // fill never exceeds depth
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= QUEUE_CW'(QUEUE_DEPTH))
        else $error("queue fill above depth");

    // push without pop grows the fill by one
    a_fill_grow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && !i_pop) |=> (r_count == $past(r_count) + 1'b1))
        else $error("queue fill did not grow on push");

    // no pop from an empty queue
    a_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> (r_count != '0))
        else $error("pop from empty queue");

endmodule

[rtl/pare_back.sv]
// ----------------------------------------------------------------------------
// pare_back
// Column and row tracking, row extent and the output register.
// ----------------------------------------------------------------------------
module pare_back
    import pare_pkg::*;
#(
    parameter int MAX_WIDTH  = 4096,
    parameter int MAX_HEIGHT = 4096
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic               i_cfg_idx,
    input  logic [CFG_W-1:0]   i_cfg_data,
    input  t_queue_out         i_q,
    output logic               o_pop,
    output logic               o_valid,
    input  logic               i_stall,
    output logic [PIXEL_W-1:0] o_pixel_out,
    output logic               o_row_done,
    output logic [FIRST_W-1:0] o_row_first,
    output logic [LAST_W-1:0]  o_row_last,
    output logic               o_frame_done
);

    localparam int CW   = $clog2(MAX_WIDTH);
    localparam int RW   = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int CMPW = ((CW > CFG_W) ? CW : CFG_W) + 1;
    localparam int CMPH = ((RW > CFG_W) ? RW : CFG_W) + 1;

    logic [CFG_W-1:0]   r_cfg_width;
    logic [CFG_W-1:0]   r_cfg_height;
    logic [CFG_W-1:0]   eff_w;
    logic [CFG_W-1:0]   eff_h;

    logic [CW-1:0]      r_col;
    logic [RW-1:0]      r_row;
    logic [CW-1:0]      r_first;
    logic [CW-1:0]      r_last;
    logic               r_seen;
    logic [CW-1:0]      n_col;
    logic [RW-1:0]      n_row;
    logic [CW-1:0]      n_first;
    logic [CW-1:0]      n_last;
    logic               n_seen;

    logic               r_ovld;
    logic [PIXEL_W-1:0] r_px;
    logic               r_row_done;
    logic [FIRST_W-1:0] r_row_first;
    logic [LAST_W-1:0]  r_row_last;
    logic               r_frame_done;
    logic               n_ovld;

    logic               last_col;
    logic               last_row;
    logic               seen_upd;
    logic [CW-1:0]      first_upd;
    logic [CW-1:0]      last_upd;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_width  <= WIDTH_RESET;
            r_cfg_height <= HEIGHT_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_IMAGE_WIDTH:  r_cfg_width  <= i_cfg_data;
                CFG_IMAGE_HEIGHT: r_cfg_height <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // effective sizes: zero reads as one, saturate at the maximum
    always_comb begin
        if (r_cfg_width == '0) begin
            eff_w = CFG_W'(1);
        end else if (CMPW'(r_cfg_width) > CMPW'(MAX_WIDTH)) begin
            eff_w = CFG_W'(MAX_WIDTH);
        end else begin
            eff_w = r_cfg_width;
        end
        if (r_cfg_height == '0) begin
            eff_h = CFG_W'(1);
        end else if (CMPH'(r_cfg_height) > CMPH'(MAX_HEIGHT)) begin
            eff_h = CFG_W'(MAX_HEIGHT);
        end else begin
            eff_h = r_cfg_height;
        end
    end

    // pop whenever the output register is free or drains this cycle
    assign o_pop = i_q.valid && (!r_ovld || !i_stall);

    // row position and extent of the popped pixel
    always_comb begin
        last_col  = (CMPW'(r_col) + CMPW'(1)) >= CMPW'(eff_w);
        last_row  = (CMPH'(r_row) + CMPH'(1)) >= CMPH'(eff_h);
        seen_upd  = r_seen || i_q.item.nz;
        first_upd = (i_q.item.nz && !r_seen) ? r_col : r_first;
        last_upd  = i_q.item.nz ? r_col : r_last;
    end

    // next state
    always_comb begin
        n_col   = r_col;
        n_row   = r_row;
        n_first = r_first;
        n_last  = r_last;
        n_seen  = r_seen;
        n_ovld  = r_ovld && i_stall;
        if (o_pop) begin
            n_ovld = 1'b1;
            if (last_col) begin
                n_col   = '0;
                n_row   = last_row ? '0 : r_row + 1'b1;
                n_seen  = 1'b0;
                n_first = '0;
                n_last  = '0;
            end else begin
                n_col   = r_col + 1'b1;
                n_seen  = seen_upd;
                n_first = first_upd;
                n_last  = last_upd;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col  <= '0;
            r_row  <= '0;
            r_seen <= 1'b0;
            r_ovld <= 1'b0;
        end else begin
            r_col  <= n_col;
            r_row  <= n_row;
            r_seen <= n_seen;
            r_ovld <= n_ovld;
        end
        r_first <= n_first;
        r_last  <= n_last;
    end

    // output register payload
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_px         <= i_q.item.px;
            r_row_done   <= last_col;
            r_frame_done <= last_col && last_row;
            if (last_col) begin
                r_row_first <= seen_upd ? FIRST_W'(first_upd) : FIRST_W'(eff_w);
                r_row_last  <= seen_upd ? LAST_W'(last_upd) : '0;
            end else begin
                r_row_first <= '0;
                r_row_last  <= '0;
            end
        end
    end

    assign o_valid      = r_ovld;
    assign o_pixel_out  = r_px;
    assign o_row_done   = r_row_done;
    assign o_row_first  = r_row_first;
    assign o_row_last   = r_row_last;
    assign o_frame_done = r_frame_done;

    // extent fields are zero away from a row end
    a_extent_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovld && !r_row_done) |-> (r_row_first == '0 && r_row_last == '0))
        else $error("extent set on a pixel that is not a row end");

    // frame end only on a row end
    a_frame_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovld && r_frame_done) |-> r_row_done)
        else $error("frame end without row end");

    // a row end always restarts the column counter
    a_col_wrap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_pop && last_col) |=> (r_col == '0 && !r_seen))
        else $error("column counter not cleared at row end");

endmodule

[rtl/premultiply_alpha_row_extent_core.sv]
// ----------------------------------------------------------------------------
// premultiply_alpha_row_extent_core
// ARGB8888 premultiply stream with per-row nonzero extent and frame end flag.
// ----------------------------------------------------------------------------
//  port group   direction  handshake          payload
//  pixel in     in         i_valid / o_stall  i_pixel_in
//  result out   out        o_valid / i_stall  o_pixel_out, o_row_done,
//                                             o_row_first, o_row_last,
//                                             o_frame_done
//  config       in         i_cfg_we           i_cfg_idx, i_cfg_data
//
//  One pixel per cycle sustained while i_stall is low; the path from input
//  transfer to the result showing at the output register runs through the
//  front stage, the queue and the back stage, in that order.
//  Reset is synchronous, active low; it clears counters and queue and loads
//  the default width and height.
//  A stalled output fills the two-entry queue, then the front stage, and only
//  then raises o_stall toward the source.
// ----------------------------------------------------------------------------
module premultiply_alpha_row_extent_core
    import pare_pkg::*;
#(
    parameter int MAX_WIDTH  = 4096,
    parameter int MAX_HEIGHT = 4096
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic               i_cfg_idx,
    input  logic [CFG_W-1:0]   i_cfg_data,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [PIXEL_W-1:0] i_pixel_in,
    output logic               o_valid,
    input  logic               i_stall,
    output logic [PIXEL_W-1:0] o_pixel_out,
    output logic               o_row_done,
    output logic [FIRST_W-1:0] o_row_first,
    output logic [LAST_W-1:0]  o_row_last,
    output logic               o_frame_done
);

    logic       push;
    logic       full;
    logic       pop;
    t_item      front_item;
    t_queue_out q_out;

    // premultiply front end
    pare_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_pixel_in (i_pixel_in),
        .o_push     (push),
        .i_full     (full),
        .o_item     (front_item)
    );

    // decoupling queue
    pare_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (front_item),
        .o_full  (full),
        .i_pop   (pop),
        .o_q     (q_out)
    );

    // row tracking back end
    pare_back #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .i_q          (q_out),
        .o_pop        (pop),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_pixel_out  (o_pixel_out),
        .o_row_done   (o_row_done),
        .o_row_first  (o_row_first),
        .o_row_last   (o_row_last),
        .o_frame_done (o_frame_done)
    );

endmodule

[bench/premultiply_alpha_row_extent_core_test.sv]
// ----------------------------------------------------------------------------
// premultiply_alpha_row_extent_core_test
// Streams ARGB pixels through the core and checks every result against an
// in-bench prediction of the premultiplied pixel, the row end flag, the row's
// nonzero extent and the frame end flag. Directed cases cover alpha extremes,
// empty rows, clamped dimensions, register rewrites with a row or frame open and
// oversized widths. Random phases then vary sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module premultiply_alpha_row_extent_core_test;
    import pare_pkg::*;

    localparam int MAX_DIM    = 4096;
    localparam int DRAIN_WAIT = 6;
    localparam int MAX_PRINTS = 40;

    // one expected result transfer
    typedef struct {
        logic [PIXEL_W-1:0] pixel;
        logic               row_done;
        logic [FIRST_W-1:0] row_first;
        logic [LAST_W-1:0]  row_last;
        logic               frame_done;
    } t_pixel_result;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_cfg_we = 1'b0;
    logic               i_cfg_idx = CFG_IMAGE_WIDTH;
    logic [CFG_W-1:0]   i_cfg_data = '0;
    logic               i_valid = 1'b0;
    logic               o_stall;
    logic [PIXEL_W-1:0] i_pixel_in = '0;
    logic               o_valid;
    logic               i_stall = 1'b0;
    logic [PIXEL_W-1:0] o_pixel_out;
    logic               o_row_done;
    logic [FIRST_W-1:0] o_row_first;
    logic [LAST_W-1:0]  o_row_last;
    logic               o_frame_done;

    // predicted block state
    logic [CFG_W-1:0]   width_reg;
    logic [CFG_W-1:0]   height_reg;
    logic [11:0]        column_pos;
    logic [11:0]        row_pos;
    logic [FIRST_W-1:0] extent_first;
    logic [LAST_W-1:0]  extent_last;
    logic               extent_seen;

    t_pixel_result pending_results[$];

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int mismatch_count = 0;
    int pixels_checked = 0;
    int rows_checked   = 0;
    int frames_checked = 0;
    int register_writes = 0;

    premultiply_alpha_row_extent_core #(
        .MAX_WIDTH  (MAX_DIM),
        .MAX_HEIGHT (MAX_DIM)
    ) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_pixel_in   (i_pixel_in),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_pixel_out  (o_pixel_out),
        .o_row_done   (o_row_done),
        .o_row_first  (o_row_first),
        .o_row_last   (o_row_last),
        .o_frame_done (o_frame_done)
    );

    // clock
    always #4 i_clk = ~i_clk;

    // zero counts as one, anything above the bound saturates
    function automatic logic [CFG_W-1:0] clamp_dim(input logic [CFG_W-1:0] v);
        if (v == '0) begin
            return 13'd1;
        end
        if (v > MAX_DIM) begin
            return 13'(MAX_DIM);
        end
        return v;
    endfunction

    function automatic logic [PIXEL_W-1:0] premultiply(input logic [PIXEL_W-1:0] px);
        logic [8:0]  scale;
        logic [16:0] r, g, b;
        if (px[31:24] == ALPHA_OPAQUE) begin
            return px;
        end
        scale = {1'b0, px[31:24]} + 9'd1;
        r = 17'(scale) * 17'(px[23:16]);
        g = 17'(scale) * 17'(px[15:8]);
        b = 17'(scale) * 17'(px[7:0]);
        return {px[31:24], r[15:8], g[15:8], b[15:8]};
    endfunction

    // advance the predicted state by one accepted pixel
    task automatic predict_pixel(input logic [PIXEL_W-1:0] px, output t_pixel_result res);
        logic [CFG_W-1:0] w, h;
        logic             end_col, end_row;
        w = clamp_dim(width_reg);
        h = clamp_dim(height_reg);
        end_col = ({1'b0, column_pos} + 13'd1) >= w;
        end_row = ({1'b0, row_pos} + 13'd1) >= h;
        res.pixel = premultiply(px);
        if (res.pixel != '0) begin
            if (!extent_seen) begin
                extent_first = {1'b0, column_pos};
            end
            extent_last = column_pos;
            extent_seen = 1'b1;
        end
        res.row_done   = end_col;
        res.row_first  = '0;
        res.row_last   = '0;
        res.frame_done = 1'b0;
        if (end_col) begin
            res.row_first  = extent_seen ? extent_first : w;
            res.row_last   = extent_seen ? extent_last : '0;
            res.frame_done = end_row;
            column_pos   = '0;
            row_pos      = end_row ? 12'd0 : row_pos + 12'd1;
            extent_seen  = 1'b0;
            extent_first = w;
            extent_last  = '0;
        end else begin
            column_pos = column_pos + 12'd1;
        end
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        mismatch_count++;
        if (mismatch_count <= MAX_PRINTS) begin
            $display("mismatch on %s after %0d results: got %h expected %h",
                     what, pixels_checked, got, want);
        end
    endtask

    // sender: optional gap, then hold the pixel until its transfer
    task automatic send_pixel(input logic [PIXEL_W-1:0] px);
        t_pixel_result res;
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid    <= 1'b1;
        i_pixel_in <= px;
        do begin
            @(posedge i_clk);
        end while (o_stall);
        predict_pixel(px, res);
        pending_results.push_back(res);
    endtask

    // idle the input and wait until every result has come out
    task automatic wait_for_results();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_results.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    // register write, only called while the block is idle
    task automatic write_register(input logic idx, input logic [CFG_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == CFG_IMAGE_WIDTH) begin
            width_reg = data;
        end else begin
            height_reg = data;
        end
        register_writes++;
        @(posedge i_clk);
    endtask

    function automatic logic [PIXEL_W-1:0] random_pixel();
        logic [PIXEL_W-1:0] px;
        px = $urandom;
        case ($urandom_range(0, 4))
            0: px[31:24] = ALPHA_OPAQUE;
            1: px[31:24] = 8'h00;
            2: px[31:24] = 8'hFE;
            default: ;
        endcase
        return px;
    endfunction

    // alpha zero always premultiplies to an all-zero pixel
    function automatic logic [PIXEL_W-1:0] clear_pixel();
        return {8'h00, 24'($urandom)};
    endfunction

    // result monitor and receiver stall
    always @(posedge i_clk) begin
        t_pixel_result want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_results.size() == 0) begin
                report_mismatch("result with nothing expected", o_pixel_out, '0);
            end else begin
                want = pending_results.pop_front();
                if (o_pixel_out !== want.pixel)
                    report_mismatch("pixel_out", o_pixel_out, want.pixel);
                if (o_row_done !== want.row_done)
                    report_mismatch("row_done", 32'(o_row_done), 32'(want.row_done));
                if (o_row_first !== want.row_first)
                    report_mismatch("row_first", 32'(o_row_first), 32'(want.row_first));
                if (o_row_last !== want.row_last)
                    report_mismatch("row_last", 32'(o_row_last), 32'(want.row_last));
                if (o_frame_done !== want.frame_done)
                    report_mismatch("frame_done", 32'(o_frame_done), 32'(want.frame_done));
                if (want.row_done) rows_checked++;
                if (want.frame_done) frames_checked++;
            end
            pixels_checked++;
        end
        i_stall <= ($urandom_range(0, 99) < recv_stall_pct);
    end

    // alpha extremes, empty row, single-column rows
    task automatic test_alpha_and_rows();
        write_register(CFG_IMAGE_WIDTH, 13'd4);
        write_register(CFG_IMAGE_HEIGHT, 13'd3);
        // nonzero extent in the middle of the row
        send_pixel(32'h0000_0000);
        send_pixel(32'hFFFF_FFFF);
        send_pixel(32'hFEFF_FFFF);
        send_pixel(32'h00FF_FFFF);
        // row with no nonzero pixel
        repeat (4) send_pixel(clear_pixel());
        // low alpha, opaque black, color-free alpha; ends the frame
        send_pixel(32'h01FF_FFFF);
        send_pixel(32'h8012_3456);
        send_pixel(32'hFF00_0000);
        send_pixel(32'h7F00_0000);
        wait_for_results();
        write_register(CFG_IMAGE_WIDTH, 13'd1);
        write_register(CFG_IMAGE_HEIGHT, 13'd2);
        send_pixel(32'h00AB_CDEF);
        send_pixel(32'h3C80_8080);
        wait_for_results();
    endtask

    // zero width and height act as one
    task automatic test_zero_dimensions();
        write_register(CFG_IMAGE_WIDTH, 13'd0);
        write_register(CFG_IMAGE_HEIGHT, 13'd0);
        send_pixel(32'h0000_0000);
        send_pixel(32'h1200_0000);
        send_pixel(32'hFFFF_FFFF);
        wait_for_results();
    endtask

    // shrink width and height while a row or a frame is open
    task automatic test_midstream_rewrite();
        write_register(CFG_IMAGE_WIDTH, 13'd16);
        write_register(CFG_IMAGE_HEIGHT, 13'd8);
        repeat (10) send_pixel(random_pixel());
        wait_for_results();
        // column already past the new bound: next pixel ends the row
        write_register(CFG_IMAGE_WIDTH, 13'd5);
        repeat (11) send_pixel(random_pixel());
        wait_for_results();
        // row already past the new bound: this row ends the frame
        write_register(CFG_IMAGE_HEIGHT, 13'd2);
        repeat (5) send_pixel(random_pixel());
        wait_for_results();
    endtask

    // oversized and exact-bound width keep the row open, then shrink to end it
    task automatic test_widest_row();
        write_register(CFG_IMAGE_WIDTH, 13'h1FFF);
        write_register(CFG_IMAGE_HEIGHT, 13'h1FFF);
        repeat (24) send_pixel(random_pixel());
        wait_for_results();
        write_register(CFG_IMAGE_WIDTH, 13'(MAX_DIM));
        repeat (12) send_pixel(clear_pixel());
        wait_for_results();
        // open row already past the new bound
        write_register(CFG_IMAGE_WIDTH, 13'd3);
        write_register(CFG_IMAGE_HEIGHT, 13'd2);
        repeat (6) send_pixel(random_pixel());
        wait_for_results();
    endtask

    // random rows with mixed density under one idling mix
    task automatic test_random_phase(input int idle_pct, input int stall_pct,
                                     input int item_goal);
        int sent;
        int chunk;
        int density;
        int k;
        logic [CFG_W-1:0] w;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        sent = 0;
        write_register(CFG_IMAGE_WIDTH, 13'($urandom_range(1, 12)));
        write_register(CFG_IMAGE_HEIGHT, 13'($urandom_range(0, 5)));
        while (sent < item_goal) begin
            w = clamp_dim(width_reg);
            chunk = $urandom_range(1, 2 * w);
            case ($urandom_range(0, 3))
                0: density = 0;
                1: density = 15;
                2: density = 60;
                default: density = 100;
            endcase
            for (k = 0; k < chunk; k++) begin
                send_pixel($urandom_range(0, 99) < density ? random_pixel() : clear_pixel());
            end
            sent += chunk;
            // now and then rewrite a register with a row or frame open
            if ($urandom_range(0, 5) == 0) begin
                wait_for_results();
                if ($urandom_range(0, 1) == 0) begin
                    write_register(CFG_IMAGE_WIDTH,
                                   $urandom_range(0, 9) == 0 ? 13'($urandom_range(0, 40))
                                                             : 13'($urandom_range(1, 12)));
                end else begin
                    write_register(CFG_IMAGE_HEIGHT, 13'($urandom_range(0, 6)));
                end
            end
        end
        wait_for_results();
    endtask

    // reset and test sequence
    initial begin
        width_reg    = WIDTH_RESET;
        height_reg   = HEIGHT_RESET;
        column_pos   = '0;
        row_pos      = '0;
        extent_first = WIDTH_RESET;
        extent_last  = '0;
        extent_seen  = 1'b0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // default geometry straight out of reset
        send_idle_pct  = 26;
        recv_stall_pct = 26;
        repeat (3) send_pixel(random_pixel());
        wait_for_results();

        test_alpha_and_rows();
        test_zero_dimensions();
        test_midstream_rewrite();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        test_widest_row();

        test_random_phase(0, 0, 140);
        test_random_phase(64, 0, 140);
        test_random_phase(0, 64, 140);
        test_random_phase(26, 26, 140);

        recv_stall_pct = 0;
        wait_for_results();
        $display("checked %0d pixels, %0d rows, %0d frames over %0d register writes",
                 pixels_checked, rows_checked, frames_checked, register_writes);
        $display("idling mixes: none, sender gaps, receiver stalls, both; %0d mismatches",
                 mismatch_count);
        if (mismatch_count == 0) begin
            $display("premultiply_alpha_row_extent_core test passed");
        end else begin
            $display("premultiply_alpha_row_extent_core test failed");
        end
        $finish;
    end

    // run limit
    initial begin
        #(8 * 400000);
        $display("premultiply_alpha_row_extent_core test failed");
        $finish;
    end

endmodule

[premultiply_alpha_row_extent_core.f]
rtl/pare_pkg.sv
rtl/pare_front.sv
rtl/pare_queue.sv
rtl/pare_back.sv
rtl/premultiply_alpha_row_extent_core.sv
bench/premultiply_alpha_row_extent_core_test.sv
